/* rtl/terminal_key_sequence_decoder_top_macros.svh */
// Assertion macros for the terminal key sequence decoder.
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_TOP_MACROS_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_TOP_MACROS_SVH
`ifndef SYNTH
// Invariant checked at every clock edge out of reset.
`define TKSD_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define TKSD_CHECK_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> conseq) else $error(msg);
`else
`define TKSD_CHECK(lbl, prop, msg)
`define TKSD_CHECK_NEXT(lbl, cond, conseq, msg)
`endif
`endif

/* rtl/tksd_pkg.sv */
// Shared types and constants of the terminal key sequence decoder.
package tksd_pkg;

    localparam int SZ_W   = 4;
    localparam int DROP_W = 4;

    // Input item kinds
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_DECODE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Decision of one decode pass
    localparam logic [1:0] ACT_STOP = 2'd0;
    localparam logic [1:0] ACT_EMIT = 2'd1;
    localparam logic [1:0] ACT_CONT = 2'd2;

    // Event kinds
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_KEY   = 2'd1;
    localparam logic [1:0] EV_CHAR  = 2'd2;
    localparam logic [1:0] EV_MOUSE = 2'd3;

    // Key codes
    localparam logic [4:0] K_NONE  = 5'd0;
    localparam logic [4:0] K_UP    = 5'd1;
    localparam logic [4:0] K_DOWN  = 5'd2;
    localparam logic [4:0] K_RIGHT = 5'd3;
    localparam logic [4:0] K_LEFT  = 5'd4;
    localparam logic [4:0] K_END   = 5'd5;
    localparam logic [4:0] K_HOME  = 5'd6;
    localparam logic [4:0] K_INS   = 5'd7;
    localparam logic [4:0] K_DEL   = 5'd8;
    localparam logic [4:0] K_PGUP  = 5'd9;
    localparam logic [4:0] K_PGDN  = 5'd10;
    localparam logic [4:0] K_F0    = 5'd10;
    localparam logic [4:0] K_TAB   = 5'd23;
    localparam logic [4:0] K_BSPC  = 5'd24;
    localparam logic [4:0] K_ENTER = 5'd25;
    localparam logic [4:0] K_ESC   = 5'd26;
    localparam logic [4:0] K_PAUSE = 5'd27;
    localparam logic [4:0] K_MOUSE = 5'd28;

    // Modifier bits: shift, alt, ctrl
    localparam logic [2:0] M_SHIFT = 3'd1;
    localparam logic [2:0] M_CTRL  = 3'd4;

    // Control bytes
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SUB  = 8'h1A;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_GS   = 8'h1D;
    localparam logic [7:0] CH_RS   = 8'h1E;
    localparam logic [7:0] CH_US   = 8'h1F;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] MOUSE_OFS = 8'h20;
    localparam logic [7:0] BTN_MASK  = 8'hE3;

    typedef struct packed {
        logic [2:0]  consumed;
        logic [1:0]  event_res;
        logic [4:0]  key_code;
        logic        mod_special;
        logic        mod_shift;
        logic        mod_alt;
        logic        mod_ctrl;
        logic [31:0] char_bytes;
        logic [2:0]  char_len;
        logic [3:0]  mouse_button;
        logic [7:0]  mouse_col;
        logic [7:0]  mouse_row;
    } res_t;

    typedef struct packed {
        logic [1:0]        act;
        logic [DROP_W-1:0] drop;
        logic              fail_inc;
        logic [1:0]        cr_next;
        logic              esc_next;
        res_t              res;
    } dec_t;

endpackage

/* rtl/tksd_ring.sv */
// Receive byte ring: one write port, one registered read port.
module tksd_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered output
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* rtl/tksd_match.sv */
// Window decoder: one decode pass over the fetched window bytes.
module tksd_match #(
    parameter int WINDOW_BYTES = 8
) (
    input  logic [WINDOW_BYTES-2:0][7:0] win,
    input  logic [tksd_pkg::SZ_W-1:0]    sz,
    input  logic [1:0]                   cr_age,
    input  logic                         esc_held,
    output tksd_pkg::dec_t               dec
);
    import tksd_pkg::*;

    localparam int SEEN = WINDOW_BYTES - 1;

    function automatic logic [4:0] letter6(input logic [7:0] c);
        logic [4:0] r;
        begin
            unique case (c)
                "A":     r = K_UP;
                "B":     r = K_DOWN;
                "C":     r = K_RIGHT;
                "D":     r = K_LEFT;
                "F":     r = K_END;
                "H":     r = K_HOME;
                default: r = K_NONE;
            endcase
            return r;
        end
    endfunction

    function automatic logic [4:0] fpqrs(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = c - 8'h50;
            if (c >= "P" && c <= "S")
                return K_F0 + 5'd1 + d[4:0];
            return K_NONE;
        end
    endfunction

    function automatic logic [4:0] vt_key(input logic [7:0] c);
        logic [4:0] r;
        begin
            unique case (c)
                "1", "7": r = K_HOME;
                "2":      r = K_INS;
                "3":      r = K_DEL;
                "4", "8": r = K_END;
                "5":      r = K_PGUP;
                "6":      r = K_PGDN;
                default:  r = K_NONE;
            endcase
            return r;
        end
    endfunction

    function automatic logic mod_ok(input logic [7:0] c);
        return c == "2" || c == "3" || c == "5" || c == "6" || c == "7";
    endfunction

    function automatic logic [2:0] mod_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = c - 8'h31;
            return d[2:0];
        end
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [3:0] f_tilde(input logic [6:0] n);
        logic [3:0] r;
        begin
            unique case (n)
                7'd11:   r = 4'd1;
                7'd12:   r = 4'd2;
                7'd13:   r = 4'd3;
                7'd14:   r = 4'd4;
                7'd15:   r = 4'd5;
                7'd17:   r = 4'd6;
                7'd18:   r = 4'd7;
                7'd19:   r = 4'd8;
                7'd20:   r = 4'd9;
                7'd21:   r = 4'd10;
                7'd23:   r = 4'd11;
                7'd24:   r = 4'd12;
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [3:0] f_caret(input logic [6:0] n);
        logic [3:0] r;
        begin
            unique case (n)
                7'd23:   r = 4'd1;
                7'd24:   r = 4'd2;
                7'd25:   r = 4'd3;
                7'd26:   r = 4'd4;
                7'd28:   r = 4'd5;
                7'd29:   r = 4'd6;
                7'd31:   r = 4'd7;
                7'd32:   r = 4'd8;
                7'd33:   r = 4'd9;
                7'd34:   r = 4'd10;
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

    // Escape sequence table match on the bytes after ESC
    logic [SZ_W-1:0] n;
    logic [2:0]      m_len;
    logic [4:0]      m_code;
    logic [2:0]      m_mods;
    logic [4:0]      c5;
    logic [3:0]      fnum;
    logic [6:0]      num;
    logic [7:0]      d1;
    logic [7:0]      d2;
    logic            hit;

    always_comb
    begin
        n      = sz - SZ_W'(1);
        m_len  = 3'd0;
        m_code = K_NONE;
        m_mods = 3'd0;
        c5     = K_NONE;
        fnum   = 4'd0;
        hit    = 1'b0;
        d1     = win[2] - 8'h30;
        d2     = win[3] - 8'h30;
        num    = {d1[3:0], 3'b000} + {2'b00, d1[3:0], 1'b0} + {3'b000, d2[3:0]};
        if (n >= SZ_W'(2) && win[1] == "O")
        begin
            m_code = fpqrs(win[2]);
            m_len  = (m_code != K_NONE) ? 3'd2 : 3'd0;
        end
        else if (n >= SZ_W'(2) && win[1] == "[")
        begin
            if (letter6(win[2]) != K_NONE)
            begin
                m_code = letter6(win[2]);
                m_len  = 3'd2;
            end
            else if (win[2] == "Z")
            begin
                m_code = K_TAB;
                m_mods = M_SHIFT;
                m_len  = 3'd2;
            end
            else
            begin
                if (n >= SZ_W'(3) && win[3] == "~" && vt_key(win[2]) != K_NONE)
                begin
                    m_code = vt_key(win[2]);
                    m_len  = 3'd3;
                    hit    = 1'b1;
                end
                // CSI digit ; modifier final
                if (!hit && n >= SZ_W'(5) && win[3] == ";" && mod_ok(win[4]))
                begin
                    if (win[2] == "1")
                    begin
                        c5 = letter6(win[5]);
                        if (c5 == K_NONE)
                            c5 = fpqrs(win[5]);
                        if (c5 == K_NONE && win[5] == "~" && mod_val(win[4]) == M_SHIFT)
                            c5 = K_HOME;
                    end
                    else if (win[5] == "~")
                    begin
                        if (win[2] == "2")
                            c5 = K_INS;
                        else if (win[2] == "3")
                            c5 = K_DEL;
                        else if (win[2] == "5")
                            c5 = K_PGUP;
                        else if (win[2] == "6")
                            c5 = K_PGDN;
                        else if (win[2] == "4" && mod_val(win[4]) == M_SHIFT)
                            c5 = K_END;
                    end
                    if (c5 != K_NONE)
                    begin
                        m_code = c5;
                        m_mods = mod_val(win[4]);
                        m_len  = 3'd5;
                        hit    = 1'b1;
                    end
                end
                // Two-digit function key forms
                if (!hit && n >= SZ_W'(4) && is_dig(win[2]) && is_dig(win[3]))
                begin
                    if (win[4] == "~")
                    begin
                        fnum = f_tilde(num);
                        if (fnum != 4'd0)
                        begin
                            m_code = K_F0 + {1'b0, fnum};
                            m_len  = 3'd4;
                        end
                    end
                    else if (win[4] == "^" || win[4] == "@")
                    begin
                        if (win[4] == "^")
                            fnum = f_caret(num);
                        else if (num == 7'd23)
                            fnum = 4'd11;
                        else if (num == 7'd24)
                            fnum = 4'd12;
                        if (fnum != 4'd0)
                        begin
                            m_code = K_F0 + {1'b0, fnum};
                            m_mods = M_SHIFT | M_CTRL;
                            m_len  = 3'd4;
                        end
                    end
                    else if (n >= SZ_W'(6) && win[4] == ";" && win[6] == "~")
                    begin
                        fnum = f_tilde(num);
                        if (mod_ok(win[5]) && fnum >= 4'd5)
                        begin
                            m_code = K_F0 + {1'b0, fnum};
                            m_mods = mod_val(win[5]);
                            m_len  = 3'd6;
                        end
                    end
                end
            end
        end
    end

    // Resync search for a later ESC
    logic              found;
    logic [DROP_W-1:0] esc_pos;

    always_comb
    begin
        found   = 1'b0;
        esc_pos = '0;
        for (int i = 1; i < SEEN; i++)
        begin
            if (!found && SZ_W'(i) < sz && win[i] == CH_ESC)
            begin
                found   = 1'b1;
                esc_pos = DROP_W'(i);
            end
        end
    end

    // UTF-8 length and byte assembly
    logic [2:0]  u_len;
    logic [31:0] u_bytes;

    always_comb
    begin
        u_bytes = '0;
        if (win[0] != 8'h00 && !win[0][7])
            u_len = 3'd1;
        else if (win[0][7:5] == 3'b110)
            u_len = 3'd2;
        else if (win[0][7:4] == 4'b1110)
            u_len = 3'd3;
        else if (win[0][7:3] == 5'b11110)
            u_len = 3'd4;
        else
            u_len = 3'd0;
        if ({1'b0, u_len} > sz)
            u_len = 3'd0;
        for (int i = 1; i < 4; i++)
        begin
            if (3'(i) < u_len && win[i][7:6] != 2'b10)
                u_len = 3'd0;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < u_len)
                u_bytes[8*i +: 8] = win[i];
        end
    end

    // Pass decision
    logic [1:0] cr_sh;
    logic [7:0] mb;
    logic [7:0] c;

    always_comb
    begin
        c            = win[0];
        cr_sh        = cr_age >> 1;
        mb           = win[3] - MOUSE_OFS;
        dec          = '0;
        dec.act      = ACT_STOP;
        dec.cr_next  = cr_sh;
        dec.esc_next = esc_held;
        if (sz > SZ_W'(1) && c == CH_ESC && win[1] != CH_ESC)
        begin
            if (sz >= SZ_W'(3))
            begin
                dec.esc_next = 1'b0;
                if (sz >= SZ_W'(6) && win[1] == "[" && win[2] == "M")
                begin
                    dec.act                  = ACT_EMIT;
                    dec.drop                 = DROP_W'(6);
                    dec.res.consumed         = 3'd6;
                    dec.res.event_res        = EV_MOUSE;
                    dec.res.key_code         = K_MOUSE;
                    dec.res.mod_shift        = mb[2];
                    dec.res.mod_alt          = mb[3];
                    dec.res.mod_ctrl         = mb[4];
                    dec.res.mouse_col        = win[4] - MOUSE_OFS;
                    dec.res.mouse_row        = win[5] - MOUSE_OFS;
                    unique case (mb & BTN_MASK)
                        8'h00:   dec.res.mouse_button = 4'd0;
                        8'h01:   dec.res.mouse_button = 4'd1;
                        8'h02:   dec.res.mouse_button = 4'd2;
                        8'h03:   dec.res.mouse_button = 4'd3;
                        8'h80:   dec.res.mouse_button = 4'd4;
                        8'h81:   dec.res.mouse_button = 4'd5;
                        8'h40:   dec.res.mouse_button = 4'd6;
                        8'h41:   dec.res.mouse_button = 4'd7;
                        default: dec.res.mouse_button = 4'd8;
                    endcase
                end
                else if (m_len != 3'd0)
                begin
                    dec.act             = ACT_EMIT;
                    dec.drop            = DROP_W'(m_len) + DROP_W'(1);
                    dec.res.consumed    = m_len + 3'd1;
                    dec.res.event_res   = EV_KEY;
                    dec.res.key_code    = m_code;
                    dec.res.mod_special = 1'b1;
                    dec.res.mod_shift   = m_mods[0];
                    dec.res.mod_alt     = m_mods[1];
                    dec.res.mod_ctrl    = m_mods[2];
                end
                else if (sz > SZ_W'(3) && found)
                begin
                    dec.act  = ACT_CONT;
                    dec.drop = esc_pos;
                end
                else
                begin
                    dec.fail_inc = 1'b1;
                end
            end
        end
        else if (c == CH_ESC && sz == SZ_W'(1) && !esc_held)
        begin
            dec.esc_next = 1'b1;
        end
        else
        begin
            dec.esc_next = 1'b0;
            if (c == CH_LF && cr_sh != 2'd0)
            begin
                dec.act     = ACT_CONT;
                dec.drop    = DROP_W'(1);
                dec.cr_next = 2'd0;
            end
            else if (c == CH_DEL || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_ESC
                     || c == CH_GS || c == CH_RS || c == CH_US)
            begin
                dec.act             = ACT_EMIT;
                dec.drop            = DROP_W'(1);
                dec.res.consumed    = 3'd1;
                dec.res.event_res   = EV_KEY;
                dec.res.mod_special = 1'b1;
                if (c == CH_CR)
                    dec.cr_next = 2'd2;
                unique case (c)
                    CH_DEL:  dec.res.key_code = K_BSPC;
                    CH_TAB:  dec.res.key_code = K_TAB;
                    CH_ESC:  dec.res.key_code = K_ESC;
                    CH_GS:   dec.res.key_code = K_PAUSE;
                    CH_US:   dec.res.key_code = K_BSPC;
                    default: dec.res.key_code = K_ENTER;
                endcase
                dec.res.mod_ctrl = (c == CH_RS || c == CH_US);
            end
            else if (c >= 8'h01 && c <= CH_SUB)
            begin
                dec.act              = ACT_EMIT;
                dec.drop             = DROP_W'(1);
                dec.res.consumed     = 3'd1;
                dec.res.event_res    = EV_CHAR;
                dec.res.mod_ctrl     = 1'b1;
                dec.res.char_bytes   = {24'd0, c + 8'h40};
                dec.res.char_len     = 3'd1;
            end
            else if (u_len != 3'd0)
            begin
                dec.act            = ACT_EMIT;
                dec.drop           = DROP_W'(u_len);
                dec.res.consumed   = u_len;
                dec.res.event_res  = EV_CHAR;
                dec.res.char_bytes = u_bytes;
                dec.res.char_len   = u_len;
            end
            else if (sz >= SZ_W'(4))
            begin
                dec.act  = ACT_CONT;
                dec.drop = DROP_W'(1);
            end
        end
    end
endmodule

/* rtl/terminal_key_sequence_decoder_top.sv */
// Top level of the terminal key sequence decoder: ring control and decode sequencer.
// Push and clear beats are taken in the idle state; a decode beat runs window passes (a fetch
// state making WINDOW_BYTES - 1 reads through the single read port, then a decide state) and
// then an output state that waits out any output stall; each dropped LF, bad byte or resync
// adds a pass. The decoder handles one item at a time.
// Reset is asynchronous: ring pointers, counters and flags clear, ring bytes stay undefined.
`include "terminal_key_sequence_decoder_top_macros.svh"
module terminal_key_sequence_decoder_top #(
    parameter int RING_DEPTH   = 64,
    parameter int WINDOW_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  consumed,
    output logic [1:0]  event_res,
    output logic [4:0]  key_code,
    output logic        mod_special,
    output logic        mod_shift,
    output logic        mod_alt,
    output logic        mod_ctrl,
    output logic [31:0] char_bytes,
    output logic [2:0]  char_len,
    output logic [3:0]  mouse_button,
    output logic [7:0]  mouse_col,
    output logic [7:0]  mouse_row
);
    import tksd_pkg::*;

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int CW   = AW + 1;
    localparam int SEEN = WINDOW_BYTES - 1;
    localparam int RW   = $clog2(SEEN + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FETCH  = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_OUT    = 3'd3;

    function automatic logic [AW-1:0] wrap(input logic [CW-1:0] s);
        logic [CW-1:0] r;
        begin
            r = (s >= CW'(RING_DEPTH)) ? s - CW'(RING_DEPTH) : s;
            return r[AW-1:0];
        end
    endfunction

    logic [2:0]                state_reg, state_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [1:0]                fail_reg, fail_next;
    logic [1:0]                cr_reg, cr_next;
    logic                      esc_reg, esc_next;
    logic [RW-1:0]             rd_idx_reg, rd_idx_next;
    logic [AW-1:0]             rd_ptr_reg, rd_ptr_next;
    logic [SEEN-1:0][7:0]      win_reg, win_next;
    res_t                      pend_reg, pend_next;
    logic                      out_valid_reg, out_valid_next;
    res_t                      out_reg, out_next;

    logic          in_accept;
    logic          push_ok;
    logic          rd_en;
    logic [7:0]    rd_data;
    logic [SZ_W-1:0] sz;
    dec_t          dec;
    logic [AW-1:0] drop_head;
    logic [CW-1:0] drop_count;
    logic [1:0]    fail_inc;
    logic          out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign push_ok   = in_accept && kind == KIND_PUSH && count_reg < CW'(RING_DEPTH);
    assign rd_en     = (state_reg == ST_FETCH) && rd_idx_reg < RW'(SEEN);
    assign sz        = (count_reg < CW'(SEEN)) ? SZ_W'(count_reg) : SZ_W'(SEEN);
    assign out_free  = !out_valid_reg || !out_stall;

    tksd_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (push_ok),
        .waddr (wrap({1'b0, head_reg} + count_reg)),
        .wdata (byte_in),
        .re    (rd_en),
        .raddr (rd_ptr_reg),
        .rdata (rd_data)
    );

    tksd_match #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_match (
        .win      (win_reg),
        .sz       (sz),
        .cr_age   (cr_reg),
        .esc_held (esc_reg),
        .dec      (dec)
    );

    assign drop_head  = wrap({1'b0, head_reg} + CW'(dec.drop));
    assign drop_count = count_reg - CW'(dec.drop);
    assign fail_inc   = fail_reg + 2'd1;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        fail_next      = fail_reg;
        cr_next        = cr_reg;
        esc_next       = esc_reg;
        rd_idx_next    = rd_idx_reg;
        rd_ptr_next    = rd_ptr_reg;
        win_next       = win_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (push_ok)
                        count_next = count_reg + CW'(1);
                    if (kind == KIND_CLEAR)
                    begin
                        fail_next = 2'd0;
                        cr_next   = 2'd0;
                        esc_next  = 1'b0;
                    end
                    if (kind == KIND_DECODE)
                    begin
                        pend_next   = '0;
                        rd_idx_next = '0;
                        rd_ptr_next = head_reg;
                        state_next  = (count_reg == '0) ? ST_OUT : ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                // Window bytes shift in from the top, first byte ends at index 0
                if (rd_idx_reg != '0)
                    win_next = {rd_data, win_reg[SEEN-1:1]};
                if (rd_en)
                    rd_ptr_next = wrap({1'b0, rd_ptr_reg} + CW'(1));
                rd_idx_next = rd_idx_reg + RW'(1);
                if (rd_idx_reg == RW'(SEEN))
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cr_next  = dec.cr_next;
                esc_next = dec.esc_next;
                unique case (dec.act)
                    ACT_EMIT:
                    begin
                        head_next  = drop_head;
                        count_next = drop_count;
                        pend_next  = dec.res;
                        state_next = ST_OUT;
                    end
                    ACT_CONT:
                    begin
                        head_next   = drop_head;
                        count_next  = drop_count;
                        rd_idx_next = '0;
                        rd_ptr_next = drop_head;
                        pend_next   = '0;
                        state_next  = (drop_count == '0) ? ST_OUT : ST_FETCH;
                    end
                    default:
                    begin
                        pend_next  = dec.res;
                        state_next = ST_OUT;
                        if (dec.fail_inc)
                        begin
                            fail_next = fail_inc;
                            if (fail_inc == 2'd3)
                            begin
                                fail_next  = 2'd0;
                                count_next = '0;
                                head_next  = '0;
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            fail_reg      <= '0;
            cr_reg        <= '0;
            esc_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            fail_reg      <= fail_next;
            cr_reg        <= cr_next;
            esc_reg       <= esc_next;
            rd_idx_reg    <= rd_idx_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign consumed     = out_reg.consumed;
    assign event_res    = out_reg.event_res;
    assign key_code     = out_reg.key_code;
    assign mod_special  = out_reg.mod_special;
    assign mod_shift    = out_reg.mod_shift;
    assign mod_alt      = out_reg.mod_alt;
    assign mod_ctrl     = out_reg.mod_ctrl;
    assign char_bytes   = out_reg.char_bytes;
    assign char_len     = out_reg.char_len;
    assign mouse_button = out_reg.mouse_button;
    assign mouse_col    = out_reg.mouse_col;
    assign mouse_row    = out_reg.mouse_row;

    `TKSD_CHECK(a_count_bound, count_reg <= CW'(RING_DEPTH), "ring count above depth")
    `TKSD_CHECK(a_fail_wrap, fail_reg != 2'd3, "fail counter reached three")
    `TKSD_CHECK(a_out_from_out, $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT, "stray beat")
    `TKSD_CHECK_NEXT(a_push_grow, push_ok, count_reg == $past(count_reg) + CW'(1), "push lost")
endmodule

/* tb/tb_terminal_key_sequence_decoder_top.sv */
// Testbench for the terminal key sequence decoder: directed cases and random key streams checked against a predictor.
module tb_terminal_key_sequence_decoder_top;
    import tksd_pkg::*;

    localparam int RING_SLOTS = 64;
    localparam int WIN_SEEN   = 7;
    localparam int STALL_LIMIT = 6000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Predictor of the decoder plus the queue of predicted events
    class key_decode_scoreboard;
        logic [7:0] ring [RING_SLOTS];
        int head, count, fails, cr_age;
        bit esc_held;
        res_t pending [$];
        int mismatches;

        function void reset_state();
            head = 0;
            count = 0;
            fails = 0;
            cr_age = 0;
            esc_held = 0;
            mismatches = 0;
        endfunction

        function void drop(int n);
            if (n > count)
                n = count;
            head = (head + n) % RING_SLOTS;
            count -= n;
        endfunction

        function int cursor_key(logic [7:0] c);
            case (c)
                "A": return K_UP;
                "B": return K_DOWN;
                "C": return K_RIGHT;
                "D": return K_LEFT;
                "F": return K_END;
                "H": return K_HOME;
                default: return K_NONE;
            endcase
        endfunction

        function int pqrs_key(logic [7:0] c);
            if (c >= "P" && c <= "S")
                return K_F0 + 1 + (c - "P");
            return K_NONE;
        endfunction

        function int vt_key(logic [7:0] c);
            case (c)
                "1", "7": return K_HOME;
                "2": return K_INS;
                "3": return K_DEL;
                "4", "8": return K_END;
                "5": return K_PGUP;
                "6": return K_PGDN;
                default: return K_NONE;
            endcase
        endfunction

        // modifier digit to shift/alt/ctrl bits, 8 when not a modifier
        function int mod_digit(logic [7:0] c);
            if (c == "2" || c == "3" || c == "5" || c == "6" || c == "7")
                return c - "1";
            return 8;
        endfunction

        function int tilde_fkey(int num);
            case (num)
                11: return 1;
                12: return 2;
                13: return 3;
                14: return 4;
                15: return 5;
                17: return 6;
                18: return 7;
                19: return 8;
                20: return 9;
                21: return 10;
                23: return 11;
                24: return 12;
                default: return 0;
            endcase
        endfunction

        function int caret_fkey(int num);
            case (num)
                23: return 1;
                24: return 2;
                25: return 3;
                26: return 4;
                28: return 5;
                29: return 6;
                31: return 7;
                32: return 8;
                33: return 9;
                34: return 10;
                default: return 0;
            endcase
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        // escape table lookup on the bytes after ESC; n bytes seen after it
        function int match_escape(logic [7:0] w [8], int n, output int code, output int mods);
            int c, m, num, f;
            mods = 0;
            code = K_NONE;
            if (n >= 2 && w[1] == "O")
            begin
                code = pqrs_key(w[2]);
                return (code != 0) ? 2 : 0;
            end
            if (n < 2 || w[1] != "[")
                return 0;
            c = cursor_key(w[2]);
            if (c != 0)
            begin
                code = c;
                return 2;
            end
            if (w[2] == "Z")
            begin
                code = K_TAB;
                mods = M_SHIFT;
                return 2;
            end
            if (n >= 3 && w[3] == "~")
            begin
                c = vt_key(w[2]);
                if (c != 0)
                begin
                    code = c;
                    return 3;
                end
            end
            if (n >= 5 && w[3] == ";")
            begin
                m = mod_digit(w[4]);
                if (m < 8)
                begin
                    c = 0;
                    if (w[2] == "1")
                    begin
                        c = cursor_key(w[5]);
                        if (c == 0)
                            c = pqrs_key(w[5]);
                        if (c == 0 && w[5] == "~" && m == M_SHIFT)
                            c = K_HOME;
                    end
                    else if (w[5] == "~")
                    begin
                        case (w[2])
                            "2": c = K_INS;
                            "3": c = K_DEL;
                            "5": c = K_PGUP;
                            "6": c = K_PGDN;
                            "4": c = (m == M_SHIFT) ? K_END : 0;
                            default: c = 0;
                        endcase
                    end
                    if (c != 0)
                    begin
                        code = c;
                        mods = m;
                        return 5;
                    end
                end
            end
            if (n >= 4 && is_digit(w[2]) && is_digit(w[3]))
            begin
                num = (w[2] - "0") * 10 + (w[3] - "0");
                f = 0;
                if (w[4] == "~")
                begin
                    f = tilde_fkey(num);
                    if (f != 0)
                    begin
                        code = K_F0 + f;
                        return 4;
                    end
                end
                else if (w[4] == "^")
                    f = caret_fkey(num);
                else if (w[4] == "@")
                    f = (num == 23) ? 11 : (num == 24) ? 12 : 0;
                else if (n >= 6 && w[4] == ";" && w[6] == "~")
                begin
                    m = mod_digit(w[5]);
                    f = tilde_fkey(num);
                    if (m < 8 && f >= 5)
                    begin
                        code = K_F0 + f;
                        mods = m;
                        return 6;
                    end
                    return 0;
                end
                if (f != 0)
                begin
                    code = K_F0 + f;
                    mods = M_SHIFT | M_CTRL;
                    return 4;
                end
            end
            return 0;
        endfunction

        function res_t key_event(int cons, int code, int mods);
            res_t r;
            r = '0;
            r.consumed = 3'(cons);
            r.event_res = EV_KEY;
            r.key_code = 5'(code);
            r.mod_special = 1'b1;
            r.mod_shift = mods[0];
            r.mod_alt = mods[1];
            r.mod_ctrl = mods[2];
            return r;
        endfunction

        function res_t char_event(int len, logic [31:0] bytes, bit ctrl);
            res_t r;
            r = '0;
            r.consumed = 3'(len);
            r.event_res = EV_CHAR;
            r.mod_ctrl = ctrl;
            r.char_bytes = bytes;
            r.char_len = 3'(len);
            return r;
        endfunction

        // one decode request: at most one event, walking the ring
        function res_t decode_event();
            res_t r;
            logic [7:0] w [8];
            logic [7:0] c, b;
            int sz, i, len, code, mods;
            bit found;
            logic [31:0] bytes;
            r = '0;
            while (count > 0)
            begin
                sz = (count < WIN_SEEN) ? count : WIN_SEEN;
                for (i = 0; i < 8; i++)
                    w[i] = (i < sz) ? ring[(head + i) % RING_SLOTS] : 8'h00;
                cr_age = cr_age >> 1;
                c = w[0];
                if (sz > 1 && c == CH_ESC && w[1] != CH_ESC)
                begin
                    if (sz < 3)
                        return r;
                    esc_held = 0;
                    if (sz >= 6 && w[1] == "[" && w[2] == "M")
                    begin
                        b = w[3] - MOUSE_OFS;
                        r.consumed = 3'd6;
                        r.event_res = EV_MOUSE;
                        r.key_code = K_MOUSE;
                        r.mod_shift = b[2];
                        r.mod_alt = b[3];
                        r.mod_ctrl = b[4];
                        case (b & BTN_MASK)
                            8'h00: r.mouse_button = 4'd0;
                            8'h01: r.mouse_button = 4'd1;
                            8'h02: r.mouse_button = 4'd2;
                            8'h03: r.mouse_button = 4'd3;
                            8'h80: r.mouse_button = 4'd4;
                            8'h81: r.mouse_button = 4'd5;
                            8'h40: r.mouse_button = 4'd6;
                            8'h41: r.mouse_button = 4'd7;
                            default: r.mouse_button = 4'd8;
                        endcase
                        r.mouse_col = w[4] - MOUSE_OFS;
                        r.mouse_row = w[5] - MOUSE_OFS;
                        drop(6);
                        return r;
                    end
                    len = match_escape(w, sz - 1, code, mods);
                    if (len != 0)
                    begin
                        r = key_event(len + 1, code, mods);
                        drop(len + 1);
                        return r;
                    end
                    found = 0;
                    if (sz > 3)
                        for (i = 1; i < sz; i++)
                            if (!found && w[i] == CH_ESC)
                            begin
                                drop(i);
                                found = 1;
                            end
                    if (found)
                        continue;
                    // unknown sequence: third one flushes the ring
                    fails = (fails + 1) & 3;
                    if (fails == 3)
                    begin
                        fails = 0;
                        count = 0;
                        head = 0;
                    end
                    return r;
                end
                if (c == CH_ESC && sz == 1 && !esc_held)
                begin
                    esc_held = 1;
                    return r;
                end
                esc_held = 0;
                if (c == CH_LF && cr_age != 0)
                begin
                    drop(1);
                    cr_age = 0;
                    continue;
                end
                mods = 0;
                case (c)
                    CH_DEL: code = K_BSPC;
                    CH_TAB: code = K_TAB;
                    CH_LF, CH_CR: code = K_ENTER;
                    CH_ESC: code = K_ESC;
                    CH_GS: code = K_PAUSE;
                    CH_RS:
                    begin
                        code = K_ENTER;
                        mods = M_CTRL;
                    end
                    CH_US:
                    begin
                        code = K_BSPC;
                        mods = M_CTRL;
                    end
                    default: code = K_NONE;
                endcase
                if (code != K_NONE)
                begin
                    if (c == CH_CR)
                        cr_age = 2;
                    r = key_event(1, code, mods);
                    drop(1);
                    return r;
                end
                if (c >= 8'h01 && c <= CH_SUB)
                begin
                    r = char_event(1, 32'("A") + c - 1, 1'b1);
                    drop(1);
                    return r;
                end
                // UTF-8 character
                len = 0;
                if (c != 0 && c < 8'h80)
                    len = 1;
                else if ((c & 8'hE0) == 8'hC0)
                    len = 2;
                else if ((c & 8'hF0) == 8'hE0)
                    len = 3;
                else if ((c & 8'hF8) == 8'hF0)
                    len = 4;
                if (len > sz)
                    len = 0;
                for (i = 1; i < 4; i++)
                    if (i < len && (w[i] & 8'hC0) != 8'h80)
                        len = 0;
                if (len != 0)
                begin
                    bytes = 0;
                    for (i = 0; i < 4; i++)
                        if (i < len)
                            bytes |= 32'(w[i]) << (8 * i);
                    r = char_event(len, bytes, 1'b0);
                    drop(len);
                    return r;
                end
                if (sz >= 4)
                    drop(1);
                else
                    return r;
            end
            return r;
        endfunction

        function void note_beat(logic [1:0] k, logic [7:0] b);
            case (k)
                KIND_PUSH:
                    if (count < RING_SLOTS)
                    begin
                        ring[(head + count) % RING_SLOTS] = b;
                        count++;
                    end
                KIND_DECODE: pending.push_back(decode_event());
                KIND_CLEAR:
                begin
                    fails = 0;
                    cr_age = 0;
                    esc_held = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(res_t got);
            res_t exp;
            if (pending.size() == 0)
            begin
                if (mismatches < 10)
                    $display("mismatch: unexpected event beat %p", got);
                mismatches++;
                return;
            end
            exp = pending.pop_front();
            if (exp !== got)
            begin
                if (mismatches < 10)
                    $display("mismatch: expected %p actual %p", exp, got);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  kind = KIND_PUSH;
    logic [7:0]  byte_in = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [2:0]  consumed;
    logic [1:0]  event_res;
    logic [4:0]  key_code;
    logic        mod_special, mod_shift, mod_alt, mod_ctrl;
    logic [31:0] char_bytes;
    logic [2:0]  char_len;
    logic [3:0]  mouse_button;
    logic [7:0]  mouse_col, mouse_row;

    key_decode_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int beats_sent = 0;
    int quiet_cycles = 0;

    terminal_key_sequence_decoder_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .byte_in(byte_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .consumed(consumed), .event_res(event_res), .key_code(key_code),
        .mod_special(mod_special), .mod_shift(mod_shift), .mod_alt(mod_alt),
        .mod_ctrl(mod_ctrl), .char_bytes(char_bytes), .char_len(char_len),
        .mouse_button(mouse_button), .mouse_col(mouse_col), .mouse_row(mouse_row)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // Result side: check accepted beats, then pick next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result('{consumed, event_res, key_code, mod_special, mod_shift,
                                  mod_alt, mod_ctrl, char_bytes, char_len, mouse_button,
                                  mouse_col, mouse_row});
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_beat(logic [1:0] k, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        byte_in <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_beat(k, b);
        beats_sent++;
    endtask

    task automatic push_bytes(logic [7:0] q [$]);
        foreach (q[i])
            send_beat(KIND_PUSH, q[i]);
    endtask

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    // Build one stimulus chunk: mostly well formed keys, some noise
    function automatic void make_chunk(ref logic [7:0] q [$]);
        int len;
        q.delete();
        case ($urandom_range(11))
            0: q = '{CH_ESC, "O", pick("PQRSAT")};
            1: q = '{CH_ESC, "[", pick("ABCDFHZE")};
            2: q = '{CH_ESC, "[", pick("123456789"), "~"};
            3: q = '{CH_ESC, "[", pick("1234568"), ";", pick("2356741"),
                     pick("ABCDFHPQRS~X")};
            4: q = '{CH_ESC, "[", pick("123"), pick("0123456789"), pick("~^@~")};
            5: q = '{CH_ESC, "[", pick("12"), pick("0123456789"), ";", pick("235674"), "~"};
            6: q = '{CH_ESC, "[", "M", 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255))};
            7: q = '{pick({CH_TAB, CH_LF, CH_CR, CH_GS, CH_RS, CH_US, CH_DEL, CH_ESC}),
                     8'($urandom_range(1, 26))};
            8: q = '{CH_CR, CH_LF};
            9:
            begin
                len = $urandom_range(1, 4);
                q.push_back(8'(len == 1 ? $urandom_range(32, 126) :
                               len == 2 ? $urandom_range(8'hC0, 8'hDF) :
                               len == 3 ? $urandom_range(8'hE0, 8'hEF) :
                                          $urandom_range(8'hF0, 8'hF7)));
                repeat (len - 1)
                    q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            default: repeat ($urandom_range(1, 6))
                q.push_back(8'($urandom_range(255)));
        endcase
    endfunction

    task automatic random_phase(int items);
        logic [7:0] q [$];
        int start;
        start = beats_sent;
        while (beats_sent - start < items)
        begin
            case ($urandom_range(19))
                0: send_beat(KIND_CLEAR, 8'($urandom_range(255)));
                1: send_beat(KIND_SPARE, 8'($urandom_range(255)));
                default:
                begin
                    make_chunk(q);
                    // broken sequences: lose the tail now and then
                    if ($urandom_range(9) == 0 && q.size() > 1)
                        q.pop_back();
                    push_bytes(q);
                end
            endcase
            repeat ($urandom_range(0, 3))
                send_beat(KIND_DECODE, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        sb.reset_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty ring, lone ESC, double ESC, CR-LF, short escape, bad UTF-8
        send_beat(KIND_DECODE, 8'h00);
        send_beat(KIND_PUSH, CH_ESC);
        send_beat(KIND_DECODE, 8'hFF);
        send_beat(KIND_DECODE, 8'h00);
        push_bytes('{CH_ESC, CH_ESC, CH_CR, CH_LF});
        send_beat(KIND_DECODE, 8'h00);
        send_beat(KIND_DECODE, 8'h00);
        send_beat(KIND_DECODE, 8'h00);
        push_bytes('{CH_ESC, "["});
        send_beat(KIND_DECODE, 8'h00);
        push_bytes('{"1", ";", "5", "A", 8'h00, 8'hFF, 8'hC3});
        send_beat(KIND_DECODE, 8'h00);
        send_beat(KIND_DECODE, 8'h00);
        send_beat(KIND_CLEAR, 8'h00);
        send_beat(KIND_SPARE, 8'hFF);
        send_beat(KIND_DECODE, 8'h00);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(350);
        send_idle_pct = 57;
        random_phase(350);
        send_idle_pct = 0;
        recv_stall_pct = 57;
        random_phase(350);
        send_idle_pct = 11;
        recv_stall_pct = 11;
        random_phase(350);

        // long receiver hold-off while decode requests keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1;
        random_phase(200);

        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
